// ----- src/hcwh_pkg.sv -----
// Shared types, constants and the sat24 helper of the hexagonal cell handoff counter.
`timescale 1ns / 1ps
`default_nettype none
package hcwh_pkg;

	localparam logic [15:0] RADIUS_RESET  = 16'd8000;
	localparam logic [16:0] SQRT3_Q16     = 17'd113512;
	localparam logic [6:0]  MAX_CROSSINGS = 7'd64;
	localparam logic [2:0]  EDGE_NONE     = 3'd7;
	localparam logic [2:0]  EDGE_COUNT    = 3'd6;

	localparam logic [1:0] MODE_PLACE = 2'd0;
	localparam logic [1:0] MODE_MOVE  = 2'd1;
	localparam logic [1:0] MODE_FINAL = 2'd2;
	localparam logic [1:0] MODE_HOLD  = 2'd3;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_OUTSIDE = 2'd1;
	localparam logic [1:0] ST_LIMIT   = 2'd2;
	localparam logic [1:0] ST_NO_EDGE = 2'd3;

	localparam logic [1:0] ORI_ZERO = 2'd0;
	localparam logic [1:0] ORI_POS  = 2'd1;
	localparam logic [1:0] ORI_NEG  = 2'd2;

	localparam logic [3:0] OP_NOP    = 4'd0;
	localparam logic [3:0] OP_PREP1  = 4'd1;
	localparam logic [3:0] OP_PREP2  = 4'd2;
	localparam logic [3:0] OP_PREP3  = 4'd3;
	localparam logic [3:0] OP_PLACE  = 4'd4;
	localparam logic [3:0] OP_MOVE   = 4'd5;
	localparam logic [3:0] OP_INS    = 4'd6;
	localparam logic [3:0] OP_ODIFF  = 4'd7;
	localparam logic [3:0] OP_OMUL   = 4'd8;
	localparam logic [3:0] OP_OSGN   = 4'd9;
	localparam logic [3:0] OP_SHIFT  = 4'd10;
	localparam logic [3:0] OP_FINISH = 4'd11;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [23:0] start_x;
		logic signed [23:0] start_y;
		logic signed [23:0] step_dx;
		logic signed [23:0] step_dy;
	} item_in_t;

	typedef struct packed {
		logic signed [23:0] out_x;
		logic signed [23:0] out_y;
		logic [6:0]         step_handoffs;
		logic [31:0]        total_handoffs;
		logic [1:0]         status;
	} item_out_t;

	typedef struct packed {
		logic       load;
		logic [3:0] op;
		logic [1:0] k;
		logic [2:0] eidx;
		logic [6:0] count;
		logic [1:0] status;
	} dp_cmd_t;

	typedef struct packed {
		logic in_hex;
		logic crosses;
	} dp_stat_t;

	function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
		logic signed [23:0] r;
		if (v > 26'sd8388607) begin
			r = 24'sh7FFFFF;
		end else if (v < -26'sd8388608) begin
			r = 24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ----- src/hcwh_chan_if.sv -----
// Valid/ready channel interface carrying one payload item.
`timescale 1ns / 1ps
`default_nettype none
interface hcwh_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- src/hcwh_dp.sv -----
// Datapath: cell geometry, node position, orientation unit and result register.
`timescale 1ns / 1ps
`default_nettype none
module hcwh_dp import hcwh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  item_in_t    item,
	input  logic        cfg_we,
	input  logic [15:0] cfg_data,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	output item_out_t   result
);

	logic [15:0]        radius_q;
	item_in_t           in_q;
	logic [32:0]        hprod_q;
	logic [15:0]        h_q;
	logic [16:0]        v_q;
	logic [33:0]        kk_q;
	logic signed [23:0] node_x_q, node_y_q, from_x_q, from_y_q;
	logic [31:0]        total_q;
	logic signed [42:0] prod_a_q, prod_b_q;
	logic signed [26:0] d1_q, d2_q, d3_q, d4_q;
	logic signed [53:0] m1_q, m2_q;
	logic [1:0]         ori_q [4];
	item_out_t          result_q;

	logic signed [17:0] hh_s, rr_s;
	logic signed [24:0] px, py;
	logic signed [43:0] ab_p, ab_m, kk_s;
	logic signed [26:0] ax, ay, bx, by, cx, cy, dx, dy;
	logic signed [26:0] ppx, ppy, pqx, pqy, prx, pry;
	logic signed [54:0] ov;
	logic [2:0]         enext;
	logic signed [25:0] shx, shy;
	logic [17:0]        v3;
	logic [32:0]        tsum;
	logic [31:0]        total_new;

	function automatic logic signed [26:0] vert_x(input logic [2:0] k,
			input logic signed [26:0] hw);
		logic signed [26:0] r;
		case (k)
			3'd0, 3'd5: r = hw;
			3'd2, 3'd3: r = -hw;
			default:    r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [26:0] vert_y(input logic [2:0] k,
			input logic signed [26:0] rr);
		logic signed [26:0] r;
		case (k)
			3'd0, 3'd2: r = rr;
			3'd1:       r = rr <<< 1;
			3'd3, 3'd5: r = -rr;
			3'd4:       r = -(rr <<< 1);
			default:    r = '0;
		endcase
		return r;
	endfunction

	function automatic logic btw(input logic signed [26:0] a, input logic signed [26:0] b,
			input logic signed [26:0] q);
		logic signed [26:0] lo, hi;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		return (q >= lo) && (q <= hi);
	endfunction

	// Doubled half-width, the radius as it is, and doubled coordinates of the node
	assign hh_s = $signed({1'b0, h_q, 1'b0});
	assign rr_s = $signed({2'b00, radius_q});
	assign px   = {node_x_q, 1'b0};
	assign py   = {node_y_q, 1'b0};

	// The six half-plane tests collapse to four bounds on H*py +/- R*px plus |px| <= H
	assign ab_p = 44'(prod_a_q) + 44'(prod_b_q);
	assign ab_m = 44'(prod_a_q) - 44'(prod_b_q);
	assign kk_s = $signed({10'b0, kk_q});
	assign stat.in_hex = (ab_p < kk_s) && (ab_m < kk_s) && (ab_p > -kk_s) && (ab_m > -kk_s)
		&& (px >= -25'(hh_s)) && (px <= 25'(hh_s));

	assign enext = (cmd.eidx == 3'd5) ? 3'd0 : cmd.eidx + 3'd1;
	assign ax = 27'($signed({from_x_q, 1'b0}));
	assign ay = 27'($signed({from_y_q, 1'b0}));
	assign bx = 27'(px);
	assign by = 27'(py);
	assign cx = vert_x(cmd.eidx, 27'(hh_s));
	assign cy = vert_y(cmd.eidx, 27'(rr_s));
	assign dx = vert_x(enext, 27'(hh_s));
	assign dy = vert_y(enext, 27'(rr_s));

	always_comb begin
		case (cmd.k)
			2'd0: begin
				ppx = ax; ppy = ay; pqx = bx; pqy = by; prx = cx; pry = cy;
			end
			2'd1: begin
				ppx = ax; ppy = ay; pqx = bx; pqy = by; prx = dx; pry = dy;
			end
			2'd2: begin
				ppx = cx; ppy = cy; pqx = dx; pqy = dy; prx = ax; pry = ay;
			end
			default: begin
				ppx = cx; ppy = cy; pqx = dx; pqy = dy; prx = bx; pry = by;
			end
		endcase
	end

	assign ov = 55'(m1_q) - 55'(m2_q);

	assign stat.crosses =
		((ori_q[0] != ori_q[1]) && (ori_q[2] != ori_q[3]))
		|| ((ori_q[0] == ORI_ZERO) && btw(ax, bx, cx) && btw(ay, by, cy))
		|| ((ori_q[1] == ORI_ZERO) && btw(ax, bx, dx) && btw(ay, by, dy))
		|| ((ori_q[2] == ORI_ZERO) && btw(cx, dx, ax) && btw(cy, dy, ay))
		|| ((ori_q[3] == ORI_ZERO) && btw(cx, dx, bx) && btw(cy, dy, by));

	always_comb begin
		case (cmd.eidx)
			3'd0: begin shx = -26'(h_q);          shy = -26'(v_q); end
			3'd1: begin shx = 26'(h_q);           shy = -26'(v_q); end
			3'd2: begin shx = 26'({h_q, 1'b0});   shy = '0;        end
			3'd3: begin shx = 26'(h_q);           shy = 26'(v_q);  end
			3'd4: begin shx = -26'(h_q);          shy = 26'(v_q);  end
			3'd5: begin shx = -26'({h_q, 1'b0});  shy = '0;        end
			default: begin shx = '0;             shy = '0;        end
		endcase
	end

	assign v3        = 18'(radius_q) * 18'd3 + 18'd1;
	assign tsum      = 33'(total_q) + 33'(cmd.count);
	assign total_new = tsum[32] ? 32'hFFFF_FFFF : tsum[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_RESET;
			node_x_q <= '0;
			node_y_q <= '0;
			from_x_q <= '0;
			from_y_q <= '0;
			total_q  <= '0;
		end else begin
			if (cfg_we) begin
				radius_q <= cfg_data;
			end
			case (cmd.op)
				OP_PLACE: begin
					node_x_q <= in_q.start_x;
					node_y_q <= in_q.start_y;
					from_x_q <= in_q.start_x;
					from_y_q <= in_q.start_y;
				end
				OP_MOVE: begin
					from_x_q <= node_x_q;
					from_y_q <= node_y_q;
					node_x_q <= sat24(26'(node_x_q) + 26'(in_q.step_dx));
					node_y_q <= sat24(26'(node_y_q) + 26'(in_q.step_dy));
				end
				OP_SHIFT: begin
					from_x_q <= sat24(26'(from_x_q) + shx);
					from_y_q <= sat24(26'(from_y_q) + shy);
					node_x_q <= sat24(26'(node_x_q) + shx);
					node_y_q <= sat24(26'(node_y_q) + shy);
				end
				OP_FINISH: begin
					total_q <= total_new;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			in_q <= item;
		end
		case (cmd.op)
			OP_PREP1: hprod_q <= 33'(radius_q) * 33'(SQRT3_Q16);
			OP_PREP2: begin
				h_q <= 16'((hprod_q + 33'd65536) >> 17);
				v_q <= v3[17:1];
			end
			OP_PREP3: kk_q <= {32'(h_q) * 32'(radius_q), 2'b00};
			OP_INS: begin
				prod_a_q <= 43'(hh_s) * 43'(py);
				prod_b_q <= 43'(rr_s) * 43'(px);
			end
			OP_ODIFF: begin
				d1_q <= pqy - ppy;
				d2_q <= prx - pqx;
				d3_q <= pqx - ppx;
				d4_q <= pry - pqy;
			end
			OP_OMUL: begin
				m1_q <= 54'(d1_q) * 54'(d2_q);
				m2_q <= 54'(d3_q) * 54'(d4_q);
			end
			OP_OSGN: ori_q[cmd.k] <= (ov == '0) ? ORI_ZERO : ((ov > 0) ? ORI_POS : ORI_NEG);
			OP_FINISH: begin
				result_q.out_x          <= node_x_q;
				result_q.out_y          <= node_y_q;
				result_q.step_handoffs  <= cmd.count;
				result_q.total_handoffs <= total_new;
				result_q.status         <= cmd.status;
			end
			default: begin
			end
		endcase
	end

	assign result = result_q;

endmodule
`default_nettype wire

// ----- src/hcwh_ctrl.sv -----
// Controller: sequences each item, as its mode requires, through preparation, wrap search and result hand-over.
`timescale 1ns / 1ps
`default_nettype none
module hcwh_ctrl import hcwh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] in_mode,
	output logic       out_valid,
	input  logic       out_ready,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PREP1 = 4'd1;
	localparam logic [3:0] S_PREP2 = 4'd2;
	localparam logic [3:0] S_PREP3 = 4'd3;
	localparam logic [3:0] S_PLACE = 4'd4;
	localparam logic [3:0] S_MOVE  = 4'd5;
	localparam logic [3:0] S_INS   = 4'd6;
	localparam logic [3:0] S_INCHK = 4'd7;
	localparam logic [3:0] S_ODIFF = 4'd8;
	localparam logic [3:0] S_OMUL  = 4'd9;
	localparam logic [3:0] S_OSGN  = 4'd10;
	localparam logic [3:0] S_EDGE  = 4'd11;
	localparam logic [3:0] S_SHIFT = 4'd12;
	localparam logic [3:0] S_DONE  = 4'd13;

	logic [3:0] state_q;
	logic [1:0] mode_q;
	logic [1:0] k_q;
	logic [2:0] eidx_q;
	logic [2:0] last_q;
	logic [6:0] count_q;
	logic [1:0] status_q;
	logic       out_valid_q;

	logic       accept;
	logic       fire;
	logic [2:0] skip;
	logic [2:0] efirst;
	logic [2:0] e1;
	logic [2:0] enext;

	assign accept   = in_valid && in_ready;
	assign in_ready = (state_q == S_IDLE);
	assign fire     = (state_q == S_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	// The edge opposite the last one crossed is never tested
	always_comb begin
		if (last_q < 3'd3) begin
			skip = last_q + 3'd3;
		end else if (last_q < EDGE_COUNT) begin
			skip = last_q - 3'd3;
		end else begin
			skip = EDGE_NONE;
		end
	end

	assign efirst = (skip == 3'd0) ? 3'd1 : 3'd0;
	assign e1     = eidx_q + 3'd1;
	assign enext  = (e1 == skip) ? e1 + 3'd1 : e1;

	always_comb begin
		cmd.load   = accept;
		cmd.k      = k_q;
		cmd.eidx   = eidx_q;
		cmd.count  = count_q;
		cmd.status = status_q;
		case (state_q)
			S_PREP1: cmd.op = OP_PREP1;
			S_PREP2: cmd.op = OP_PREP2;
			S_PREP3: cmd.op = OP_PREP3;
			S_PLACE: cmd.op = OP_PLACE;
			S_MOVE:  cmd.op = OP_MOVE;
			S_INS:   cmd.op = OP_INS;
			S_ODIFF: cmd.op = OP_ODIFF;
			S_OMUL:  cmd.op = OP_OMUL;
			S_OSGN:  cmd.op = OP_OSGN;
			S_SHIFT: cmd.op = OP_SHIFT;
			S_DONE:  cmd.op = fire ? OP_FINISH : OP_NOP;
			default: cmd.op = OP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			mode_q      <= MODE_PLACE;
			k_q         <= '0;
			eidx_q      <= '0;
			last_q      <= EDGE_NONE;
			count_q     <= '0;
			status_q    <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready && !fire) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q   <= in_mode;
						count_q  <= '0;
						status_q <= ST_OK;
						last_q   <= EDGE_NONE;
						case (in_mode)
							MODE_HOLD:  state_q <= S_DONE;
							MODE_FINAL: state_q <= S_MOVE;
							default:    state_q <= S_PREP1;
						endcase
					end
				end
				S_PREP1: state_q <= S_PREP2;
				S_PREP2: state_q <= S_PREP3;
				S_PREP3: state_q <= (mode_q == MODE_PLACE) ? S_PLACE : S_MOVE;
				S_PLACE: state_q <= S_INS;
				S_MOVE: begin
					if (mode_q == MODE_FINAL) begin
						count_q <= 7'd1;
						state_q <= S_DONE;
					end else begin
						state_q <= S_INS;
					end
				end
				S_INS: state_q <= S_INCHK;
				S_INCHK: begin
					if (stat.in_hex) begin
						state_q <= S_DONE;
					end else if (mode_q == MODE_PLACE) begin
						status_q <= ST_OUTSIDE;
						state_q  <= S_DONE;
					end else if (count_q >= MAX_CROSSINGS) begin
						status_q <= ST_LIMIT;
						state_q  <= S_DONE;
					end else begin
						eidx_q  <= efirst;
						k_q     <= '0;
						state_q <= S_ODIFF;
					end
				end
				S_ODIFF: state_q <= S_OMUL;
				S_OMUL:  state_q <= S_OSGN;
				S_OSGN: begin
					k_q     <= k_q + 2'd1;
					state_q <= (k_q == 2'd3) ? S_EDGE : S_ODIFF;
				end
				S_EDGE: begin
					if (stat.crosses) begin
						state_q <= S_SHIFT;
					end else if (enext >= EDGE_COUNT) begin
						status_q <= ST_NO_EDGE;
						state_q  <= S_DONE;
					end else begin
						eidx_q  <= enext;
						k_q     <= '0;
						state_q <= S_ODIFF;
					end
				end
				S_SHIFT: begin
					last_q  <= eidx_q;
					count_q <= count_q + 7'd1;
					state_q <= S_INS;
				end
				S_DONE: begin
					if (fire) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_edge_allowed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EDGE) |-> (eidx_q < EDGE_COUNT) && (eidx_q != skip))
		else $error("edge under test is out of range or opposite the last crossing");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= MAX_CROSSINGS)
		else $error("handoff count passed the crossing limit");

	a_shift_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SHIFT) |=> (state_q == S_INS) && (count_q == $past(count_q) + 7'd1))
		else $error("shift did not count one handoff and recheck the position");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted item did not start processing");

endmodule
`default_nettype wire

// ----- src/hex_cell_wraparound_handoff_counter.sv -----
// Top level of the hexagonal cell wrap-around handoff counter.
//
// The block follows one mobile node inside a pointy-top hexagonal cell centred
// on the origin. Items arrive on item_in (valid/ready); each carries a mode and
// either a start point (place) or a displacement (move with wrap, final move).
// Every item gives exactly one result item on item_out: the node position, the
// handoffs counted for this item, the running total and a status code.
// The cfg channel writes the cell radius; it is always ready and must only be
// used while the block is idle.
// A hold item goes straight to the result; a final move makes its move and
// counts one handoff; a placement or a move runs the preparation, the position
// update and the inside check. Each wrap adds edge tests, each made of
// orientation tests through the shared difference/multiply unit, plus the
// shift and recheck. Items are processed one at a time.
// Reset clears the position, the leg record and the total, and loads the
// default radius. The result sits in an output register: while the receiver
// stalls, the next item is accepted and worked on, and it waits at the end
// only if the previous result has still not been taken.
`timescale 1ns / 1ps
`default_nettype none
module hex_cell_wraparound_handoff_counter import hcwh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	hcwh_chan_if.sink   item_in,
	hcwh_chan_if.source item_out,
	hcwh_chan_if.sink   cfg
);

	dp_cmd_t   cmd;
	dp_stat_t  stat;
	item_out_t result;

	// The radius register accepts a write in any cycle
	assign cfg.ready = 1'b1;

	hcwh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item_in.valid),
		.in_ready  (item_in.ready),
		.in_mode   (item_in.data.mode),
		.out_valid (item_out.valid),
		.out_ready (item_out.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	hcwh_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.item     (item_in.data),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.cmd      (cmd),
		.stat     (stat),
		.result   (result)
	);

	assign item_out.data = result;

endmodule
`default_nettype wire

// ----- sim/hex_cell_wraparound_handoff_counter_tb.sv -----
// Self-checking testbench of the hexagonal cell wrap-around handoff counter.
`timescale 1ns / 1ps
module hex_cell_wraparound_handoff_counter_tb;
	import hcwh_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// The clock runs at a 12 ns period, high and low for half of it each.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	hcwh_chan_if #(.payload_t(item_in_t))    item_in();
	hcwh_chan_if #(.payload_t(item_out_t))   item_out();
	hcwh_chan_if #(.payload_t(logic [15:0])) cfg();

	hex_cell_wraparound_handoff_counter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.item_in(item_in),
		.item_out(item_out),
		.cfg(cfg)
	);

	// The predictor keeps its own copy of the node state and the radius.
	longint unsigned radius_q;
	longint pos_x, pos_y, leg_x, leg_y;
	int unsigned prev_edge;
	int unsigned total_q;

	item_in_t  pending_items[$];
	item_out_t expected_results[$];
	int unsigned mismatches = 0;
	bit idle_off = 1'b0;
	bit sender_hold = 1'b0;
	bit stim_done = 1'b0;
	bit in_taken = 1'b0;

	function automatic longint clamp24(longint v);
		if (v > 64'sd8388607) return 64'sd8388607;
		if (v < -64'sd8388608) return -64'sd8388608;
		return v;
	endfunction

	function automatic longint half_w();
		return longint'((radius_q * 64'd113512 + 64'd65536) >> 17);
	endfunction

	// Corner k of the cell, in doubled coordinates.
	function automatic void corner(int unsigned k, output longint cx, output longint cy);
		int sx[6];
		int sy[6];
		sx = '{1, 0, -1, -1, 0, 1};
		sy = '{1, 2, 1, -1, -2, -1};
		k = k % 6;
		cx = sx[k] * 2 * half_w();
		cy = sy[k] * longint'(radius_q);
	endfunction

	// The vertical edges count a point on them as inside, the slanted ones do not.
	function automatic bit in_cell(longint x, longint y);
		longint ax, ay, bx, by, c;
		for (int i = 0; i < 6; i++) begin
			corner(i, ax, ay);
			corner(i + 1, bx, by);
			c = (bx - ax) * (2 * y - ay) - (by - ay) * (2 * x - ax);
			if (i == 2 || i == 5) begin
				if (c < 0) return 1'b0;
			end else if (c <= 0) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic int turn(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		longint v;
		v = (qy - py) * (rx - qx) - (qx - px) * (ry - qy);
		if (v == 0) return 0;
		return (v > 0) ? 1 : 2;
	endfunction

	function automatic bit on_span(longint px, longint py, longint qx, longint qy,
			longint rx, longint ry);
		return (qx >= ((px < rx) ? px : rx)) && (qx <= ((px < rx) ? rx : px)) &&
			(qy >= ((py < ry) ? py : ry)) && (qy <= ((py < ry) ? ry : py));
	endfunction

	function automatic bit leg_crosses(longint ax, longint ay, longint bx, longint by,
			int unsigned e);
		longint cx, cy, dx, dy;
		int o1, o2, o3, o4;
		corner(e, cx, cy);
		corner(e + 1, dx, dy);
		o1 = turn(ax, ay, bx, by, cx, cy);
		o2 = turn(ax, ay, bx, by, dx, dy);
		o3 = turn(cx, cy, dx, dy, ax, ay);
		o4 = turn(cx, cy, dx, dy, bx, by);
		if (o1 != o2 && o3 != o4) return 1'b1;
		if (o1 == 0 && on_span(ax, ay, cx, cy, bx, by)) return 1'b1;
		if (o2 == 0 && on_span(ax, ay, dx, dy, bx, by)) return 1'b1;
		if (o3 == 0 && on_span(cx, cy, ax, ay, dx, dy)) return 1'b1;
		if (o4 == 0 && on_span(cx, cy, bx, by, dx, dy)) return 1'b1;
		return 1'b0;
	endfunction

	// Works out the result of one item and advances the predicted state.
	function automatic item_out_t track_node(item_in_t it);
		item_out_t r;
		int unsigned count, found, skip;
		logic [1:0] st;
		longint h, v;
		longint shx[6];
		longint shy[6];
		count = 0;
		st = ST_OK;
		if (it.mode == MODE_PLACE) begin
			pos_x = longint'(it.start_x);
			pos_y = longint'(it.start_y);
			leg_x = pos_x;
			leg_y = pos_y;
			prev_edge = EDGE_NONE;
			if (!in_cell(pos_x, pos_y)) st = ST_OUTSIDE;
		end else if (it.mode == MODE_MOVE || it.mode == MODE_FINAL) begin
			leg_x = pos_x;
			leg_y = pos_y;
			prev_edge = EDGE_NONE;
			pos_x = clamp24(pos_x + longint'(it.step_dx));
			pos_y = clamp24(pos_y + longint'(it.step_dy));
			if (it.mode == MODE_FINAL) begin
				count = 1;
			end else begin
				h = half_w();
				v = longint'((3 * radius_q + 1) >> 1);
				shx = '{-h, h, 2 * h, h, -h, -2 * h};
				shy = '{-v, -v, 0, v, v, 0};
				while (!in_cell(pos_x, pos_y)) begin
					found = EDGE_NONE;
					skip = (prev_edge < 6) ? (prev_edge + 3) % 6 : EDGE_NONE;
					if (count >= MAX_CROSSINGS) begin
						st = ST_LIMIT;
						break;
					end
					for (int e = 0; e < 6; e++) begin
						if (e != skip && found == EDGE_NONE &&
								leg_crosses(2 * leg_x, 2 * leg_y, 2 * pos_x, 2 * pos_y, e))
							found = e;
					end
					if (found == EDGE_NONE) begin
						st = ST_NO_EDGE;
						break;
					end
					leg_x = clamp24(leg_x + shx[found]);
					leg_y = clamp24(leg_y + shy[found]);
					pos_x = clamp24(pos_x + shx[found]);
					pos_y = clamp24(pos_y + shy[found]);
					prev_edge = found;
					count++;
				end
			end
			if (total_q > 32'hFFFF_FFFF - count) total_q = 32'hFFFF_FFFF;
			else total_q = total_q + count;
		end
		r.out_x = pos_x[23:0];
		r.out_y = pos_y[23:0];
		r.step_handoffs = count[6:0];
		r.total_handoffs = total_q;
		r.status = st;
		return r;
	endfunction

	// Driver: presents the oldest pending item, changing inputs on the falling edge.
	// Valid stays high until the item is taken, so it is never lowered and raised
	// within one step.
	initial begin
		item_in.valid = 1'b0;
		item_in.data = '0;
		cfg.valid = 1'b0;
		cfg.data = '0;
		item_out.ready = 1'b0;
	end

	// Input acceptance is sampled at the rising edge for the driver to act on.
	always @(posedge clk) begin
		in_taken <= arst_n && item_in.valid && item_in.ready;
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				// Accepted at the last rising edge, so the item is predicted now.
				expected_results.push_back(track_node(pending_items.pop_front()));
			end
			if (!item_in.valid || in_taken) begin
				if (pending_items.size() > 0 && !sender_hold &&
						(idle_off || $urandom_range(99) >= 25)) begin
					item_in.valid <= 1'b1;
					item_in.data <= pending_items[0];
				end else begin
					item_in.valid <= 1'b0;
				end
			end
			item_out.ready <= idle_off || ($urandom_range(99) >= 25);
		end
	end

	// Monitor: compares each result item taken with the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && item_out.valid && item_out.ready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result item: %p", item_out.data);
			end else begin
				item_out_t ex;
				ex = expected_results.pop_front();
				if (ex !== item_out.data) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %p, actual %p", ex, item_out.data);
				end
			end
		end
	end

	// Waits until every item handed to the driver has been taken and answered.
	task automatic drain();
		while (pending_items.size() > 0 || item_in.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_radius(logic [15:0] value);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.data <= value;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
		radius_q = value;
	endtask

	function automatic item_in_t make_item(logic [1:0] m, longint a, longint b);
		item_in_t it;
		it.mode = m;
		it.start_x = 24'($urandom());
		it.start_y = 24'($urandom());
		it.step_dx = 24'($urandom());
		it.step_dy = 24'($urandom());
		if (m == MODE_PLACE) begin
			it.start_x = a[23:0];
			it.start_y = b[23:0];
		end else begin
			it.step_dx = a[23:0];
			it.step_dy = b[23:0];
		end
		return it;
	endfunction

	// Coordinates mostly scaled to the cell, so that legs cross a few cells.
	function automatic longint near_value(int span);
		int r;
		r = $urandom_range(9);
		if (r == 0) return longint'($signed($urandom() & 32'hFF_FFFF) <<< 8) >>> 8;
		if (r == 1) return ($urandom_range(1)) ? 64'sd8388607 : -64'sd8388608;
		return longint'($urandom_range(2 * span)) - span;
	endfunction

	task automatic random_phase(int n);
		int span;
		logic [1:0] m;
		for (int i = 0; i < n; i++) begin
			span = (radius_q < 64) ? 64 : int'(radius_q) * (1 + $urandom_range(4));
			case ($urandom_range(9))
				0: m = MODE_PLACE;
				1: m = MODE_FINAL;
				2: m = MODE_HOLD;
				default: m = MODE_MOVE;
			endcase
			pending_items.push_back(make_item(m, near_value(span), near_value(span)));
		end
	endtask

	initial begin
		logic [15:0] radii[5];
		radii = '{16'd8000, 16'd16, 16'd65535, 16'd300, 16'd5};
		radius_q = RADIUS_RESET;
		pos_x = 0;
		pos_y = 0;
		leg_x = 0;
		leg_y = 0;
		prev_edge = EDGE_NONE;
		total_q = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed items with the reset radius: corners, edges and field extremes.
		pending_items.push_back(make_item(MODE_HOLD, 0, 0));
		pending_items.push_back(make_item(MODE_PLACE, 0, 0));
		pending_items.push_back(make_item(MODE_PLACE, 6928, 0));
		pending_items.push_back(make_item(MODE_PLACE, 0, 8000));
		pending_items.push_back(make_item(MODE_PLACE, 8388607, -8388608));
		pending_items.push_back(make_item(MODE_PLACE, 0, 0));
		pending_items.push_back(make_item(MODE_MOVE, 10000, 0));
		pending_items.push_back(make_item(MODE_MOVE, 0, 20000));
		pending_items.push_back(make_item(MODE_MOVE, -8388608, -8388608));
		pending_items.push_back(make_item(MODE_MOVE, 8388607, 8388607));
		pending_items.push_back(make_item(MODE_FINAL, 8388607, 8388607));
		pending_items.push_back(make_item(MODE_FINAL, -8388608, 0));
		pending_items.push_back(make_item(MODE_MOVE, 0, 0));
		pending_items.push_back(make_item(MODE_PLACE, 6928, 4000));
		pending_items.push_back(make_item(MODE_MOVE, 6928, 4000));
		pending_items.push_back(make_item(MODE_HOLD, 0, 0));
		drain();

		// Each radius, extremes included, gets a phase of random items. One phase
		// runs without idling, and in each phase the sender holds off once until drained.
		for (int p = 0; p < 5; p++) begin
			write_radius(radii[(p + 1) % 5]);
			pending_items.push_back(make_item(MODE_PLACE, 0, 0));
			idle_off = (p == 2);
			random_phase(110);
			while (pending_items.size() > 55) @(posedge clk);
			sender_hold = 1'b1;
			while (expected_results.size() > 0 || item_in.valid) @(posedge clk);
			sender_hold = 1'b0;
			random_phase(110);
			drain();
		end
		idle_off = 1'b0;
		write_radius(16'd8000);
		random_phase(20);
		drain();
		stim_done = 1'b1;
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// This timeout far exceeds any correct run, even with items at the crossing limit.
	initial begin
		#400_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
